/* rtl/core/ifmt_pkg.sv */
package ifmt_pkg;

  // Format codes carried in the cmd field
  localparam logic [2:0] CMD_DEC   = 3'd0;
  localparam logic [2:0] CMD_HEXU  = 3'd1;
  localparam logic [2:0] CMD_HEXL  = 3'd2;
  localparam logic [2:0] CMD_BIN8  = 3'd3;
  localparam logic [2:0] CMD_BIN32 = 3'd4;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3f;

  localparam int unsigned WGT_W = 34;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
  } ifmt_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } ifmt_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE0,
    S_PRE1,
    S_HEX,
    S_BIN,
    S_SPACE,
    S_DEC_CALC,
    S_DEC_EMIT
  } ifmt_state_e;

  // Weight of one BCD bit: 10^pos scaled by 2^bit
  function automatic logic [WGT_W-1:0] dec_weight(logic [3:0] pos, logic [1:0] bitsel);
    logic [WGT_W-1:0] p;
    case (pos)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p << bitsel;
  endfunction

endpackage

/* rtl/core/ifmt_sub_unit.sv */
// Shared compare-subtract unit; builds one decimal digit MSB bit first.
module ifmt_sub_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] mag_i,
  input  logic        step_i,
  input  logic [3:0]  pos_i,
  input  logic [1:0]  bit_i,
  output logic [3:0]  digit_o
);

  logic [31:0]                  rem_q, rem_d;
  logic [3:0]                   digit_q, digit_d;
  logic [ifmt_pkg::WGT_W-1:0]   wgt;
  logic [ifmt_pkg::WGT_W-1:0]   diff;
  logic                         ge;

  assign wgt  = ifmt_pkg::dec_weight(pos_i, bit_i);
  assign diff = {2'b00, rem_q} - wgt;
  assign ge   = ({2'b00, rem_q} >= wgt);

  always_comb begin
    rem_d   = rem_q;
    digit_d = digit_q;
    if (load_i) begin
      rem_d   = mag_i;
      digit_d = '0;
    end else if (step_i) begin
      if (ge) begin
        rem_d = diff[31:0];
      end
      // first bit of a digit clears the rest
      if (bit_i == 2'd3) begin
        digit_d = {ge, 3'b000};
      end else begin
        digit_d[bit_i] = ge;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      digit_q <= '0;
    end else begin
      rem_q   <= rem_d;
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

/* rtl/core/integer_to_ascii_formatter_unit.sv */
// Order: hex, binary and negative decimal words begin with a prefix character; decimal
//   digits are built by compare-subtract steps, then emitted, for 10 positions.
// One item at a time: a new word is accepted only after the last character of the previous
//   word has entered the output register; output stalls hold the sequencer.
// Reset: asynchronous active-low rst_ni returns the sequencer to idle, output empty.
module integer_to_ascii_formatter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ifmt_pkg::ifmt_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ifmt_pkg::ifmt_out_t out_word_o
);

  ifmt_pkg::ifmt_state_e state_q, state_d;

  logic [2:0]  cmd_q, cmd_d;
  logic [31:0] sh_q, sh_d;        // hex/binary shift register, MSB first
  logic [5:0]  cnt_q, cnt_d;      // nibbles or bits still to send
  logic [3:0]  pos_q, pos_d;      // decimal position
  logic [1:0]  bit_q, bit_d;      // BCD bit within a digit
  logic        started_q, started_d;

  logic        out_valid_q;
  ifmt_pkg::ifmt_out_t out_q;

  logic        accept;
  logic        stall;
  logic        emit;
  logic        emit_last;
  logic [7:0]  emit_char;
  logic        adv;              // current character taken into output register
  logic        dec_skip;
  logic [31:0] mag;
  logic [3:0]  digit;
  logic [3:0]  nib;
  logic [7:0]  alpha;
  logic        step;

  assign in_ready_o = (state_q == ifmt_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign stall      = out_valid_q && !out_ready_i;
  assign adv        = emit && !stall;

  // two's complement magnitude; the most negative value wraps to its unsigned magnitude
  assign mag = in_word_i.value[31] ? (~in_word_i.value + 32'd1) : in_word_i.value;

  assign nib   = sh_q[31:28];
  assign alpha = (cmd_q == ifmt_pkg::CMD_HEXL) ? ifmt_pkg::CH_LA : ifmt_pkg::CH_UA;
  // leading zeros are dropped, except the units digit
  assign dec_skip = (digit == 4'd0) && !started_q && (pos_q != 4'd0);
  assign step     = (state_q == ifmt_pkg::S_DEC_CALC);

  ifmt_sub_unit u_sub (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .mag_i   (mag),
    .step_i  (step),
    .pos_i   (pos_q),
    .bit_i   (bit_q),
    .digit_o (digit)
  );

  // Character selection
  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_char = ifmt_pkg::CH_QMARK;
    case (state_q)
      ifmt_pkg::S_PRE0: begin
        emit = 1'b1;
        case (cmd_q)
          ifmt_pkg::CMD_DEC:   emit_char = ifmt_pkg::CH_MINUS;
          ifmt_pkg::CMD_HEXU,
          ifmt_pkg::CMD_HEXL:  emit_char = ifmt_pkg::CH_ZERO;
          ifmt_pkg::CMD_BIN8,
          ifmt_pkg::CMD_BIN32: emit_char = ifmt_pkg::CH_B;
          default: begin
            emit_char = ifmt_pkg::CH_QMARK;
            emit_last = 1'b1;
          end
        endcase
      end
      ifmt_pkg::S_PRE1: begin
        emit      = 1'b1;
        emit_char = ifmt_pkg::CH_X;
      end
      ifmt_pkg::S_HEX: begin
        emit      = 1'b1;
        emit_last = (cnt_q == 6'd1);
        emit_char = (nib < 4'd10) ? (ifmt_pkg::CH_ZERO + {4'd0, nib})
                                  : (alpha + {4'd0, nib} - 8'd10);
      end
      ifmt_pkg::S_BIN: begin
        emit      = 1'b1;
        emit_last = (cnt_q == 6'd1);
        emit_char = ifmt_pkg::CH_ZERO + {7'd0, sh_q[31]};
      end
      ifmt_pkg::S_SPACE: begin
        emit      = 1'b1;
        emit_char = ifmt_pkg::CH_SPACE;
      end
      ifmt_pkg::S_DEC_EMIT: begin
        emit      = !dec_skip;
        emit_last = (pos_q == 4'd0);
        emit_char = ifmt_pkg::CH_ZERO + {4'd0, digit};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    sh_d      = sh_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    bit_d     = bit_q;
    started_d = started_q;
    case (state_q)
      ifmt_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d     = in_word_i.cmd;
          pos_d     = 4'd9;
          bit_d     = 2'd3;
          started_d = 1'b0;
          if (in_word_i.cmd == ifmt_pkg::CMD_BIN8) begin
            sh_d  = {in_word_i.value[7:0], 24'd0};
            cnt_d = 6'd8;
          end else if (in_word_i.cmd == ifmt_pkg::CMD_BIN32) begin
            sh_d  = in_word_i.value;
            cnt_d = 6'd32;
          end else begin
            sh_d  = in_word_i.value;
            cnt_d = 6'd8;
          end
          if (in_word_i.cmd == ifmt_pkg::CMD_DEC && !in_word_i.value[31]) begin
            state_d = ifmt_pkg::S_DEC_CALC;
          end else begin
            state_d = ifmt_pkg::S_PRE0;
          end
        end
      end
      ifmt_pkg::S_PRE0: begin
        if (adv) begin
          case (cmd_q)
            ifmt_pkg::CMD_DEC:   state_d = ifmt_pkg::S_DEC_CALC;
            ifmt_pkg::CMD_HEXU,
            ifmt_pkg::CMD_HEXL:  state_d = ifmt_pkg::S_PRE1;
            ifmt_pkg::CMD_BIN8,
            ifmt_pkg::CMD_BIN32: state_d = ifmt_pkg::S_BIN;
            default:             state_d = ifmt_pkg::S_IDLE;
          endcase
        end
      end
      ifmt_pkg::S_PRE1: begin
        if (adv) state_d = ifmt_pkg::S_HEX;
      end
      ifmt_pkg::S_HEX: begin
        if (adv) begin
          sh_d  = {sh_q[27:0], 4'd0};
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_d = ifmt_pkg::S_IDLE;
        end
      end
      ifmt_pkg::S_BIN: begin
        if (adv) begin
          sh_d  = {sh_q[30:0], 1'b0};
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_d = ifmt_pkg::S_IDLE;
          end else if (cnt_q[1:0] == 2'b01) begin
            // a full group of four just went out
            state_d = ifmt_pkg::S_SPACE;
          end
        end
      end
      ifmt_pkg::S_SPACE: begin
        if (adv) state_d = ifmt_pkg::S_BIN;
      end
      ifmt_pkg::S_DEC_CALC: begin
        bit_d = bit_q - 2'd1;
        if (bit_q == 2'd0) state_d = ifmt_pkg::S_DEC_EMIT;
      end
      ifmt_pkg::S_DEC_EMIT: begin
        if (dec_skip || adv) begin
          started_d = 1'b1;
          if (dec_skip) started_d = started_q;
          bit_d = 2'd3;
          if (pos_q == 4'd0) begin
            state_d = ifmt_pkg::S_IDLE;
          end else begin
            pos_d   = pos_q - 4'd1;
            state_d = ifmt_pkg::S_DEC_CALC;
          end
        end
      end
      default: begin
        state_d = ifmt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ifmt_pkg::S_IDLE;
      started_q <= 1'b0;
      cnt_q     <= '0;
      pos_q     <= '0;
      bit_q     <= '0;
      cmd_q     <= '0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      bit_q     <= bit_d;
      cmd_q     <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  // Output register: holds one word until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!stall) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.char_code <= emit_char;
      out_q.last      <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
